### rtl/erc_pkg.sv
// ----------------------------------------------------------------------------
// erc_pkg: shared types and constants
// Widths, stage counts and the arctangent table for the remap pipeline.
// ----------------------------------------------------------------------------
package erc_pkg;

  localparam int PREVIEW_MAX  = 4096;
  localparam int ANGLE_STAGES = 24;
  localparam int ISQ_STEPS    = 31;
  localparam int RAY_LAT      = 5;
  localparam int SQRT_LAT     = ISQ_STEPS + 2;
  localparam int CORDIC_LAT   = ANGLE_STAGES + 1;

  localparam int PIX_W  = 12;
  localparam int PROD_W = 45;
  localparam int RAY_W  = 47;
  localparam int NORM_W = 30;
  localparam int VEC_W  = 32;
  localparam int CXY_W  = 36;
  localparam int ANG_W  = 34;
  localparam int DIM_W  = 15;
  localparam int OUT_W  = 21;
  localparam int SCL_W  = 50;
  localparam int SQ_W   = 62;

  localparam int NORM_MSB = NORM_W - 1;

  localparam logic [2:0] REG_M00_M01 = 3'd0;
  localparam logic [2:0] REG_M02_M10 = 3'd1;
  localparam logic [2:0] REG_M11_M12 = 3'd2;
  localparam logic [2:0] REG_M20_M21 = 3'd3;
  localparam logic [2:0] REG_M22     = 3'd4;
  localparam logic [2:0] REG_WIDTH   = 3'd5;
  localparam logic [2:0] REG_HEIGHT  = 3'd6;

  localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(64'sd2147483648);
  localparam logic signed [SCL_W-1:0] U_MAX     = SCL_W'(1048576);
  localparam logic signed [SCL_W-1:0] V_MIN     = -SCL_W'(262144);
  localparam logic signed [SCL_W-1:0] V_MAX     = SCL_W'(786432);

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } coef_t;

  typedef struct packed {
    logic                    vld;
    logic signed [VEC_W-1:0] nx;
    logic signed [VEC_W-1:0] ny;
    logic signed [VEC_W-1:0] nz;
    logic [NORM_W-1:0]       ax;
    logic [NORM_W-1:0]       az;
  } ray_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    case (idx)
      5'd0:  atan_turn = 32'h20000000;
      5'd1:  atan_turn = 32'h12E4051E;
      5'd2:  atan_turn = 32'h09FB385B;
      5'd3:  atan_turn = 32'h051111D4;
      5'd4:  atan_turn = 32'h028B0D43;
      5'd5:  atan_turn = 32'h0145D7E1;
      5'd6:  atan_turn = 32'h00A2F61E;
      5'd7:  atan_turn = 32'h00517C55;
      5'd8:  atan_turn = 32'h0028BE53;
      5'd9:  atan_turn = 32'h00145F2F;
      5'd10: atan_turn = 32'h000A2F98;
      5'd11: atan_turn = 32'h000517CC;
      5'd12: atan_turn = 32'h00028BE6;
      5'd13: atan_turn = 32'h000145F3;
      5'd14: atan_turn = 32'h0000A2FA;
      5'd15: atan_turn = 32'h0000517D;
      5'd16: atan_turn = 32'h000028BE;
      5'd17: atan_turn = 32'h0000145F;
      5'd18: atan_turn = 32'h00000A30;
      5'd19: atan_turn = 32'h00000518;
      5'd20: atan_turn = 32'h0000028C;
      5'd21: atan_turn = 32'h00000146;
      5'd22: atan_turn = 32'h000000A3;
      5'd23: atan_turn = 32'h00000051;
      5'd24: atan_turn = 32'h00000029;
      5'd25: atan_turn = 32'h00000014;
      5'd26: atan_turn = 32'h0000000A;
      5'd27: atan_turn = 32'h00000005;
      5'd28: atan_turn = 32'h00000003;
      5'd29: atan_turn = 32'h00000001;
      5'd30: atan_turn = 32'h00000001;
      default: atan_turn = 32'h00000000;
    endcase
  endfunction

endpackage

### rtl/equirect_remap_coordinate.sv
// ----------------------------------------------------------------------------
// equirect_remap_coordinate: equirectangular remap coordinate generator
// Maps a preview pixel through a 3x3 matrix to a ray and returns its source
// coordinates in an equirectangular image.
// ----------------------------------------------------------------------------
// The block takes one pixel in every clock cycle and never holds start off,
// so busy stays low. Each result appears on map_u and map_v for one cycle
// with done high, in input order, after passing through the ray stages, the
// bit-per-stage square root, the vertical angle pipeline and the scaling
// stages. The receiver must take every result in the cycle it appears.
// Configuration writes are always ready and must only be made with no pixel
// in flight.
module equirect_remap_coordinate (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [erc_pkg::PIX_W-1:0]        pixel_x,
  input  logic [erc_pkg::PIX_W-1:0]        pixel_y,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [2:0]                       cfg_index,
  input  logic [63:0]                      cfg_data,
  output logic                             done,
  output logic [erc_pkg::OUT_W-1:0]        map_u,
  output logic signed [erc_pkg::OUT_W-1:0] map_v
);

  localparam int SL = erc_pkg::SQRT_LAT;

  logic [63:0] reg0, reg1, reg2, reg3;
  logic [31:0] reg_m22;
  logic [erc_pkg::DIM_W-1:0] width, height;
  erc_pkg::coef_t coef;
  erc_pkg::ray_t  ray;

  logic                                 tu_vld, sq_vld, tv_vld;
  logic signed [erc_pkg::ANG_W-1:0]     tu, tv;
  logic signed [erc_pkg::VEC_W-1:0]     root;
  logic signed [erc_pkg::VEC_W-1:0]     ny_dly [0:SL-1];
  logic signed [erc_pkg::ANG_W-1:0]     tu_dly [0:SL-1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg0    <= '0;
      reg1    <= '0;
      reg2    <= '0;
      reg3    <= '0;
      reg_m22 <= 32'd16777216;
      width   <= erc_pkg::DIM_W'(4096);
      height  <= erc_pkg::DIM_W'(2048);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        erc_pkg::REG_M00_M01: reg0    <= cfg_data;
        erc_pkg::REG_M02_M10: reg1    <= cfg_data;
        erc_pkg::REG_M11_M12: reg2    <= cfg_data;
        erc_pkg::REG_M20_M21: reg3    <= cfg_data;
        erc_pkg::REG_M22:     reg_m22 <= cfg_data[31:0];
        erc_pkg::REG_WIDTH:   width   <= cfg_data[erc_pkg::DIM_W-1:0];
        erc_pkg::REG_HEIGHT:  height  <= cfg_data[erc_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.m00 = $signed(reg0[31:0]);
    coef.m01 = $signed(reg0[63:32]);
    coef.m02 = $signed(reg1[31:0]);
    coef.m10 = $signed(reg1[63:32]);
    coef.m11 = $signed(reg2[31:0]);
    coef.m12 = $signed(reg2[63:32]);
    coef.m20 = $signed(reg3[31:0]);
    coef.m21 = $signed(reg3[63:32]);
    coef.m22 = $signed(reg_m22);
  end

  erc_ray u_ray (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (start && !busy),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .coef    (coef),
    .ray     (ray)
  );

  erc_cordic u_cordic_u (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (ray.vld),
    .a       (ray.nx),
    .b       (ray.nz),
    .out_vld (tu_vld),
    .angle   (tu)
  );

  erc_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (ray.vld),
    .ax      (ray.ax),
    .az      (ray.az),
    .out_vld (sq_vld),
    .root    (root)
  );

  always_ff @(posedge clk) begin
    ny_dly[0] <= ray.ny;
    tu_dly[0] <= tu;
    for (int i = 1; i < SL; i++) begin
      ny_dly[i] <= ny_dly[i-1];
      tu_dly[i] <= tu_dly[i-1];
    end
  end

  erc_cordic u_cordic_v (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (sq_vld),
    .a       (ny_dly[SL-1]),
    .b       (root),
    .out_vld (tv_vld),
    .angle   (tv)
  );

  erc_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .in_vld       (tv_vld),
    .tu           (tu_dly[SL-1]),
    .tv           (tv),
    .image_width  (width),
    .image_height (height),
    .done         (done),
    .map_u        (map_u),
    .map_v        (map_v)
  );

  assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  assert property (@(posedge clk) disable iff (rst)
    done |-> (map_u <= erc_pkg::OUT_W'(1048576)))
    else $error("map_u above its range");

  assert property (@(posedge clk) disable iff (rst)
    done |-> (map_v >= erc_pkg::V_MIN) && (map_v <= erc_pkg::V_MAX))
    else $error("map_v outside its range");

  assert property (@(posedge clk) disable iff (rst)
    tv_vld |-> $past(tu_vld, erc_pkg::SQRT_LAT))
    else $error("angle pipelines out of step");

endmodule

### rtl/erc_ray.sv
// ----------------------------------------------------------------------------
// erc_ray: ray generation and normalization
// Multiplies (x, y, 1) by the matrix, takes magnitudes and scales the ray so
// that its largest component has its leading one at bit 29.
// ----------------------------------------------------------------------------
module erc_ray (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_vld,
  input  logic [erc_pkg::PIX_W-1:0]      pixel_x,
  input  logic [erc_pkg::PIX_W-1:0]      pixel_y,
  input  erc_pkg::coef_t                 coef,
  output erc_pkg::ray_t                  ray
);

  localparam int PW = erc_pkg::PROD_W;
  localparam int RW = erc_pkg::RAY_W;
  localparam int NW = erc_pkg::NORM_W;
  localparam int VW = erc_pkg::VEC_W;

  logic [erc_pkg::PIX_W-1:0] px_cl, py_cl;
  logic signed [PW-1:0] pxs, pys;

  logic                 vld1, vld2, vld3, vld4;
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [RW-1:0] rx, ry, rz;
  logic [RW-1:0]        ax, ay, az;
  logic                 sx, sy, sz;
  logic [RW-1:0]        ax4, ay4, az4;
  logic                 sx4, sy4, sz4;
  logic [5:0]           msb4;
  logic                 nonzero4;

  logic [RW-1:0] mor;
  logic [5:0]    msb_next;
  logic [RW-1:0] shx, shy, shz;

  always_comb begin
    px_cl = (32'(pixel_x) > 32'(erc_pkg::PREVIEW_MAX - 1)) ?
            erc_pkg::PIX_W'(erc_pkg::PREVIEW_MAX - 1) : pixel_x;
    py_cl = (32'(pixel_y) > 32'(erc_pkg::PREVIEW_MAX - 1)) ?
            erc_pkg::PIX_W'(erc_pkg::PREVIEW_MAX - 1) : pixel_y;
    pxs = $signed(PW'(px_cl));
    pys = $signed(PW'(py_cl));
  end

  always_comb begin
    mor = ax | ay | az;
    msb_next = '0;
    for (int i = 0; i < RW; i++) begin
      if (mor[i]) begin
        msb_next = 6'(i);
      end
    end
  end

  always_comb begin
    if (msb4 > 6'(NW - 1)) begin
      shx = ax4 >> (msb4 - 6'(NW - 1));
      shy = ay4 >> (msb4 - 6'(NW - 1));
      shz = az4 >> (msb4 - 6'(NW - 1));
    end else begin
      shx = ax4 << (6'(NW - 1) - msb4);
      shy = ay4 << (6'(NW - 1) - msb4);
      shz = az4 << (6'(NW - 1) - msb4);
    end
    if (!nonzero4) begin
      shx = '0;
      shy = '0;
      shz = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      vld4    <= 1'b0;
      ray.vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      vld2    <= vld1;
      vld3    <= vld2;
      vld4    <= vld3;
      ray.vld <= vld4;
    end
    p0 <= PW'(coef.m00) * pxs;
    p1 <= PW'(coef.m01) * pys;
    p2 <= PW'(coef.m10) * pxs;
    p3 <= PW'(coef.m11) * pys;
    p4 <= PW'(coef.m20) * pxs;
    p5 <= PW'(coef.m21) * pys;
    rx <= RW'(p0) + RW'(p1) + RW'(coef.m02);
    ry <= RW'(p2) + RW'(p3) + RW'(coef.m12);
    rz <= RW'(p4) + RW'(p5) + RW'(coef.m22);
    sx <= rx[RW-1];
    sy <= ry[RW-1];
    sz <= rz[RW-1];
    ax <= rx[RW-1] ? RW'(-rx) : RW'(rx);
    ay <= ry[RW-1] ? RW'(-ry) : RW'(ry);
    az <= rz[RW-1] ? RW'(-rz) : RW'(rz);
    ax4 <= ax;
    ay4 <= ay;
    az4 <= az;
    sx4 <= sx;
    sy4 <= sy;
    sz4 <= sz;
    msb4 <= msb_next;
    nonzero4 <= |mor;
    ray.ax <= shx[NW-1:0];
    ray.az <= shz[NW-1:0];
    ray.nx <= sx4 ? -$signed(VW'(shx[NW-1:0])) : $signed(VW'(shx[NW-1:0]));
    ray.ny <= sy4 ? -$signed(VW'(shy[NW-1:0])) : $signed(VW'(shy[NW-1:0]));
    ray.nz <= sz4 ? -$signed(VW'(shz[NW-1:0])) : $signed(VW'(shz[NW-1:0]));
  end

endmodule

### rtl/erc_isqrt.sv
// ----------------------------------------------------------------------------
// erc_isqrt: pipelined integer square root
// Computes floor(sqrt(ax^2 + az^2)), one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module erc_isqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_vld,
  input  logic [erc_pkg::NORM_W-1:0]     ax,
  input  logic [erc_pkg::NORM_W-1:0]     az,
  output logic                           out_vld,
  output logic signed [erc_pkg::VEC_W-1:0] root
);

  localparam int N  = erc_pkg::ISQ_STEPS;
  localparam int SW = erc_pkg::SQ_W;

  logic          vld_sq, vld_sum;
  logic [SW-1:0] sqx, sqz, nsum;
  logic [SW-1:0] op_q  [0:N];
  logic [SW-1:0] res_q [0:N];
  logic [N:0]    vld_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sq  <= 1'b0;
      vld_sum <= 1'b0;
    end else begin
      vld_sq  <= in_vld;
      vld_sum <= vld_sq;
    end
    sqx  <= SW'(ax) * SW'(ax);
    sqz  <= SW'(az) * SW'(az);
    nsum <= sqx + sqz;
  end

  assign op_q[0]  = nsum;
  assign res_q[0] = '0;
  assign vld_q[0] = vld_sum;

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [SW-1:0] ONE = SW'(1) << (2 * (N - 1 - k));
    logic [SW-1:0] trial;
    assign trial = res_q[k] + ONE;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
      if (op_q[k] >= trial) begin
        op_q[k+1]  <= op_q[k] - trial;
        res_q[k+1] <= (res_q[k] >> 1) + ONE;
      end else begin
        op_q[k+1]  <= op_q[k];
        res_q[k+1] <= res_q[k] >> 1;
      end
    end
  end

  assign out_vld = vld_q[N];
  assign root    = $signed(res_q[N][erc_pkg::VEC_W-1:0]);

endmodule

### rtl/erc_cordic.sv
// ----------------------------------------------------------------------------
// erc_cordic: vectoring CORDIC angle pipeline
// Returns atan2(a, b) as a binary angle, 2^32 units to the turn.
// ----------------------------------------------------------------------------
module erc_cordic (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_vld,
  input  logic signed [erc_pkg::VEC_W-1:0] a,
  input  logic signed [erc_pkg::VEC_W-1:0] b,
  output logic                             out_vld,
  output logic signed [erc_pkg::ANG_W-1:0] angle
);

  localparam int N  = erc_pkg::ANGLE_STAGES;
  localparam int XW = erc_pkg::CXY_W;
  localparam int ZW = erc_pkg::ANG_W;

  logic signed [XW-1:0] x_q [0:N];
  logic signed [XW-1:0] y_q [0:N];
  logic signed [ZW-1:0] z_q [0:N];
  logic [N:0]           vld_q;
  logic [N:0]           zero_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= in_vld;
    end
    zero_q[0] <= (a == '0) && (b == '0);
    if (b < 0) begin
      x_q[0] <= -XW'(b);
      y_q[0] <= -XW'(a);
      z_q[0] <= (a >= 0) ? erc_pkg::HALF_TURN : -erc_pkg::HALF_TURN;
    end else begin
      x_q[0] <= XW'(b);
      y_q[0] <= XW'(a);
      z_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN = $signed(ZW'(erc_pkg::atan_turn(5'(i))));
    logic signed [XW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
      zero_q[i+1] <= zero_q[i];
      if (y_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + ATAN;
      end else begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - ATAN;
      end
    end
  end

  assign out_vld = vld_q[N];
  assign angle   = zero_q[N] ? '0 : z_q[N];

endmodule

### rtl/erc_scale.sv
// ----------------------------------------------------------------------------
// erc_scale: angle to pixel scaling
// Scales both angles by the source width, rounds, adds the image centre and
// saturates to the output ranges.
// ----------------------------------------------------------------------------
module erc_scale (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_vld,
  input  logic signed [erc_pkg::ANG_W-1:0] tu,
  input  logic signed [erc_pkg::ANG_W-1:0] tv,
  input  logic [erc_pkg::DIM_W-1:0]        image_width,
  input  logic [erc_pkg::DIM_W-1:0]        image_height,
  output logic                             done,
  output logic [erc_pkg::OUT_W-1:0]        map_u,
  output logic signed [erc_pkg::OUT_W-1:0] map_v
);

  localparam int SW = erc_pkg::SCL_W;
  localparam logic signed [SW-1:0] RND = SW'(1) <<< 25;

  logic                 vld1;
  logic signed [SW-1:0] pu, pv, ws;
  logic signed [SW-1:0] u_full, v_full, u_sat, v_sat;

  assign ws = $signed(SW'(image_width));

  always_comb begin
    u_full = ((pu + RND) >>> 26) + (ws <<< 5);
    v_full = ((pv + RND) >>> 26) + ($signed(SW'(image_height)) <<< 5);
    u_sat  = (u_full < 0) ? '0 : ((u_full > erc_pkg::U_MAX) ? erc_pkg::U_MAX : u_full);
    v_sat  = (v_full < erc_pkg::V_MIN) ? erc_pkg::V_MIN :
             ((v_full > erc_pkg::V_MAX) ? erc_pkg::V_MAX : v_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      done <= 1'b0;
    end else begin
      vld1 <= in_vld;
      done <= vld1;
    end
    pu    <= SW'(tu) * ws;
    pv    <= SW'(tv) * ws;
    map_u <= u_sat[erc_pkg::OUT_W-1:0];
    map_v <= v_sat[erc_pkg::OUT_W-1:0];
  end

endmodule
